// File: src/skl_pkg.sv
`timescale 1ns / 1ps

package skl_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned IdxW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned KeyW    = 8;
  localparam int unsigned HandleW = 8;
  localparam int unsigned StatW   = 2;
  localparam int unsigned PosW    = 5;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpClear  = 2'd2,
    OpNop    = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    StDone    = 2'd0,
    StFull    = 2'd1,
    StMissing = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } skl_in_t;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] position;
    logic [PosW-1:0] entry_count;
  } skl_out_t;

  typedef struct packed {
    logic               used;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } skl_entry_t;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic               insert_en;
    logic               remove_en;
    logic               clear_en;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } skl_cmd_t;

  // What a cell hands to its upper neighbor.
  typedef struct packed {
    logic       le;
    logic       hit;
    skl_entry_t entry;
  } skl_link_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } skl_mark_t;

endpackage

// File: src/skl_cell.sv
`timescale 1ns / 1ps

module skl_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skl_pkg::skl_cmd_t   cmd_i,
  input  skl_pkg::skl_link_t  prev_i,
  input  skl_pkg::skl_entry_t next_entry_i,
  output skl_pkg::skl_link_t  link_o,
  output skl_pkg::skl_mark_t  mark_o
);

  skl_pkg::skl_entry_t entry_q, entry_d;
  logic le, match;

  assign le    = entry_q.used && (entry_q.key <= cmd_i.key);
  assign match = entry_q.used && (entry_q.key == cmd_i.key) &&
                 (entry_q.handle == cmd_i.handle);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.clear_en) begin
      entry_d = '0;
    end else if (cmd_i.insert_en) begin
      // The list is sorted, so le cells form a prefix; the first cell past it takes
      // the new entry and every cell above takes its lower neighbor.
      if (le) begin
        entry_d = entry_q;
      end else if (prev_i.le) begin
        entry_d.used   = 1'b1;
        entry_d.key    = cmd_i.key;
        entry_d.handle = cmd_i.handle;
      end else begin
        entry_d = prev_i.entry;
      end
    end else if (cmd_i.remove_en && (prev_i.hit || match)) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign link_o.le    = le;
  assign link_o.hit   = prev_i.hit || match;
  assign link_o.entry = entry_q;

  assign mark_o.ins = !le && prev_i.le;
  assign mark_o.rem = match && !prev_i.hit;

endmodule

// File: src/sorted_key_list_engine_core.sv
`timescale 1ns / 1ps
// A result beat is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the input is not stalled; every cell of the row compares and shifts in
// the same cycle, and a registered output stage holds the result.
// Input stalls only while a result waits and the output is stalled.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result.

module sorted_key_list_engine_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  skl_pkg::skl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output skl_pkg::skl_out_t out_data_o
);

  localparam int unsigned Depth = skl_pkg::Depth;
  localparam int unsigned IdxW  = skl_pkg::IdxW;
  localparam int unsigned CntW  = skl_pkg::CntW;

  logic                    accept;
  logic                    full;
  logic                    found;
  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q;
  skl_pkg::skl_out_t       out_q, result;
  skl_pkg::skl_cmd_t       cmd;
  skl_pkg::skl_link_t      head;
  skl_pkg::skl_link_t      link [Depth];
  skl_pkg::skl_mark_t      mark [Depth];
  logic [Depth-1:0]        used_vec;
  logic [IdxW-1:0]         ins_idx, rem_idx;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(Depth));

  assign cmd.insert_en = accept && (in_data_i.op == skl_pkg::OpInsert) && !full;
  assign cmd.remove_en = accept && (in_data_i.op == skl_pkg::OpRemove);
  assign cmd.clear_en  = accept && (in_data_i.op == skl_pkg::OpClear);
  assign cmd.key       = in_data_i.key;
  assign cmd.handle    = in_data_i.handle;

  // Below slot 0 everything counts as ordered before the new key.
  assign head.le    = 1'b1;
  assign head.hit   = 1'b0;
  assign head.entry = '0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    skl_pkg::skl_link_t  prev;
    skl_pkg::skl_entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev = head;
    end else begin : g_mid
      assign prev = link[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = link[i+1].entry;
    end

    skl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_i       (prev),
      .next_entry_i (next_entry),
      .link_o       (link[i]),
      .mark_o       (mark[i])
    );

    assign used_vec[i] = link[i].entry.used;
  end

  assign found = link[Depth-1].hit;

  always_comb begin
    ins_idx = '0;
    rem_idx = '0;
    for (int i = 0; i < Depth; i++) begin
      if (mark[i].ins) begin
        ins_idx = ins_idx | IdxW'(i);
      end
      if (mark[i].rem) begin
        rem_idx = rem_idx | IdxW'(i);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.clear_en) begin
      count_d = '0;
    end else if (cmd.insert_en) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.remove_en && found) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    result.status   = skl_pkg::StDone;
    result.position = '0;
    unique case (in_data_i.op)
      skl_pkg::OpInsert: begin
        if (full) begin
          result.status = skl_pkg::StFull;
        end else begin
          result.position = skl_pkg::PosW'(ins_idx);
        end
      end
      skl_pkg::OpRemove: begin
        if (found) begin
          result.position = skl_pkg::PosW'(rem_idx);
        end else begin
          result.status = skl_pkg::StMissing;
        end
      end
      default: begin
        result.status = skl_pkg::StDone;
      end
    endcase
    result.entry_count = skl_pkg::PosW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count above depth");

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_vec) == int'(count_q))
    else $error("used slots disagree with entry count");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert_en |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the list");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == skl_pkg::StFull) |->
      out_data_o.entry_count == skl_pkg::PosW'(Depth))
    else $error("full status on a list that is not full");
`endif

endmodule
